// ----- design/icp_pkg.sv -----
// ----------------------------------------------------------------------------
// icp_pkg
// Shared types and constants of the complementary-filter pitch unit:
// controller/datapath command and status bundles, register map, arctangent
// table and fixed-point limits.
// ----------------------------------------------------------------------------
package icp_pkg;

   localparam int ANG_TAB_LEN  = 24;   // arctangent table entries
   localparam int SQRT_STEPS   = 16;   // two radicand bits per step
   localparam int DVD_W        = 26;
   localparam int XY_W         = 27;
   localparam int Z_W          = 25;

   // floor(n / 131) = (n * ceil(2^33 / 131)) >> 33, exact for n < 2^26
   localparam logic [DVD_W-1:0] DIV_RECIP = 26'd65572020;
   localparam int               DIV_SHIFT = 33;
   localparam logic [25:0] DIV_BIAS   = 26'd17170432; // 131 << 17, keeps dividend positive
   localparam int          PITCH_LIM  = 46080;
   localparam int          ACC_LIM    = 23040;

   // register map
   localparam logic [1:0] CSR_SAMPLE_PERIOD = 2'd0;
   localparam logic [1:0] CSR_GYRO_OFFSET   = 2'd1;
   localparam logic [1:0] CSR_GYRO_WEIGHT   = 2'd2;

   localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd655;
   localparam logic [15:0] GYRO_OFFSET_RST   = 16'd0;
   localparam logic [15:0] GYRO_WEIGHT_RST   = 16'd58982;

   typedef struct packed {
      logic       load;         // capture the input transaction
      logic       square;       // form ax^2+az^2, start the rate divider
      logic       sqrt_step;
      logic       cordic_init;
      logic       cordic_step;
      logic       angle;        // round the angle, form pitch minus delta
      logic       prod;
      logic       final_step;   // blend, clamp, load the result register
      logic [4:0] idx;          // iteration index
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } sts_type;

   // atan(2^-i) in degrees, Q16
   function automatic logic [21:0] atan_q16(input logic [4:0] i);
      logic [21:0] r;
      unique case (i)
         5'd0:    r = 22'd2949120;
         5'd1:    r = 22'd1740967;
         5'd2:    r = 22'd919879;
         5'd3:    r = 22'd466945;
         5'd4:    r = 22'd234379;
         5'd5:    r = 22'd117304;
         5'd6:    r = 22'd58666;
         5'd7:    r = 22'd29335;
         5'd8:    r = 22'd14668;
         5'd9:    r = 22'd7334;
         5'd10:   r = 22'd3667;
         5'd11:   r = 22'd1833;
         5'd12:   r = 22'd917;
         5'd13:   r = 22'd458;
         5'd14:   r = 22'd229;
         5'd15:   r = 22'd115;
         5'd16:   r = 22'd57;
         5'd17:   r = 22'd29;
         5'd18:   r = 22'd14;
         5'd19:   r = 22'd7;
         5'd20:   r = 22'd4;
         5'd21:   r = 22'd2;
         5'd22:   r = 22'd1;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- design/icp_ctrl.sv -----
// ----------------------------------------------------------------------------
// icp_ctrl
// Sequencer of the pitch unit: steps the datapath through square, root,
// CORDIC vectoring, blend and result hand-off, and owns the result valid.
// ----------------------------------------------------------------------------
module icp_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output icp_pkg::cmd_type cmd,
   input  icp_pkg::sts_type sts
);
   import icp_pkg::*;

   localparam int NUM_ITER = (CORDIC_STEPS < ANG_TAB_LEN) ? CORDIC_STEPS : ANG_TAB_LEN;
   localparam logic [4:0] LAST_ITER = 5'(NUM_ITER - 1);
   localparam logic [4:0] LAST_SQRT = 5'(SQRT_STEPS - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SQUARE, S_SQRT, S_CINIT, S_CORDIC, S_ANGLE, S_PROD, S_FINAL
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.idx      = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            cnt_in     = '0;
            state_in   = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 5'd1;
            if (cnt_ff == LAST_SQRT) begin
               state_in = S_CINIT;
            end
         end
         S_CINIT: begin
            cmd.cordic_init = 1'b1;
            cnt_in          = '0;
            state_in        = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            cnt_in          = cnt_ff + 5'd1;
            if (cnt_ff == LAST_ITER) begin
               state_in = S_ANGLE;
            end
         end
         S_ANGLE: begin
            // holds until the gyro delta is ready
            if (sts.div_done) begin
               cmd.angle = 1'b1;
               state_in  = S_PROD;
            end
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (out_free) begin
               cmd.final_step = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_prod_after_div : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROD) |-> $past(sts.div_done))
      else $error("blend started before the rate divider finished");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINAL && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_FINAL))
      else $error("pending result overwritten");

   a_one_cmd : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.square, cmd.sqrt_step, cmd.cordic_init,
                cmd.cordic_step, cmd.angle, cmd.prod, cmd.final_step}))
      else $error("more than one datapath command");

   a_iter_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CORDIC) |-> (cnt_ff <= LAST_ITER))
      else $error("CORDIC index past last iteration");
`endif

endmodule

// ----- design/icp_dp.sv -----
// ----------------------------------------------------------------------------
// icp_dp
// Datapath of the pitch unit: digit-by-digit square root, CORDIC vectoring
// unit, reciprocal-multiply divide by 131 for the gyro delta, blend and clamp.
// ----------------------------------------------------------------------------
module icp_dp (
   input  logic                clock,
   input  logic                reset,
   input  icp_pkg::cmd_type    cmd,
   output icp_pkg::sts_type    sts,
   input  logic [63:0]         req_tdata,
   input  logic [15:0]         sample_period,
   input  logic signed [15:0]  gyro_offset,
   input  logic [15:0]         gyro_weight,
   output logic signed [16:0]  pitch_estimate,
   output logic signed [15:0]  accel_pitch,
   output logic                saturated
);
   import icp_pkg::*;

   // captured sample
   logic signed [15:0] ax_ff, ay_ff, az_ff, gx_ff;

   // square root
   logic [31:0] sq_ff, sq_in;
   logic [15:0] root_ff, root_in;
   logic [17:0] rem_ff, rem_in;
   logic [19:0] rem_cat, trial;
   logic        sqrt_ge;

   // cordic
   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [Z_W-1:0]  z_ff, z_in, tab;
   logic                   zero_ff;
   logic signed [16:0]     neg_ay;

   // rate divider
   logic signed [16:0]   rate;
   logic signed [33:0]   rate_prod, rate_rnd;
   logic [DVD_W-1:0]     dvd_ff;
   logic [2*DVD_W-1:0]   quo_full;
   logic [17:0]          quo_ff;
   logic                 div_busy_ff;

   // blend
   logic signed [Z_W-1:0] z_rnd;
   logic signed [16:0]    z_deg;
   logic signed [15:0]    acc_ff, acc_in, acc_out_ff;
   logic signed [18:0]    delta;
   logic signed [19:0]    p1_ff;
   logic [16:0]           acc_w;
   logic signed [36:0]    prod_g_ff;
   logic signed [33:0]    prod_a_ff;
   logic signed [37:0]    blend;
   logic signed [21:0]    np;
   logic signed [16:0]    pitch_ff, pitch_in;
   logic                  sat_ff, sat_in;

   // ---- square root step: two radicand bits per cycle
   assign rem_cat = {rem_ff, sq_ff[31:30]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign sqrt_ge = (rem_cat >= trial);

   always_comb begin
      sq_in   = {sq_ff[29:0], 2'b00};
      root_in = {root_ff[14:0], sqrt_ge};
      rem_in  = sqrt_ge ? 18'(rem_cat - trial) : rem_cat[17:0];
   end

   // ---- cordic step
   assign neg_ay = -$signed({ay_ff[15], ay_ff});
   assign xs     = x_ff >>> cmd.idx;
   assign ys     = y_ff >>> cmd.idx;
   assign tab    = $signed({3'b000, atan_q16(cmd.idx)});

   always_comb begin
      if (!y_ff[XY_W-1]) begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + tab;
      end else begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - tab;
      end
   end

   // ---- rate divider: floor((rate*dt + 16768) / 33536) as a shift then /131
   assign rate      = $signed({gx_ff[15], gx_ff}) - $signed({gyro_offset[15], gyro_offset});
   assign rate_prod = rate * $signed({1'b0, sample_period});
   assign rate_rnd  = rate_prod + 34'sd16768;
   assign quo_full  = dvd_ff * DIV_RECIP;

   assign sts.div_done = !div_busy_ff;

   // ---- angle rounding and gyro delta
   assign z_rnd = z_ff + 25'sd128;
   assign z_deg = z_rnd[Z_W-1:8];
   assign delta = $signed({1'b0, quo_ff}) - 19'sd131072;

   always_comb begin
      priority if (zero_ff) begin
         acc_in = '0;
      end else if (z_deg > 17'sd23040) begin
         acc_in = 16'(ACC_LIM);
      end else if (z_deg < -17'sd23040) begin
         acc_in = -16'(ACC_LIM);
      end else begin
         acc_in = z_deg[15:0];
      end
   end

   // ---- blend and clamp
   assign acc_w = 17'(18'd65536 - {2'b00, gyro_weight});
   assign blend = {{1{prod_g_ff[36]}}, prod_g_ff} + {{4{prod_a_ff[33]}}, prod_a_ff}
                + 38'sd32768;
   assign np    = blend[37:16];

   always_comb begin
      sat_in = 1'b1;
      priority if (np > 22'sd46080) begin
         pitch_in = 17'(PITCH_LIM);
      end else if (np < -22'sd46080) begin
         pitch_in = -17'(PITCH_LIM);
      end else begin
         pitch_in = np[16:0];
         sat_in   = 1'b0;
      end
   end

   // ---- registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff <= req_tdata[15:0];
         ay_ff <= req_tdata[31:16];
         az_ff <= req_tdata[47:32];
         gx_ff <= req_tdata[63:48];
      end
      if (cmd.square) begin
         sq_ff   <= 32'(ax_ff * ax_ff) + 32'(az_ff * az_ff);
         root_ff <= '0;
         rem_ff  <= '0;
         dvd_ff  <= rate_rnd[33:8] + DIV_BIAS;
      end else if (cmd.sqrt_step) begin
         sq_ff   <= sq_in;
         root_ff <= root_in;
         rem_ff  <= rem_in;
      end
      if (div_busy_ff) begin
         quo_ff <= quo_full[DIV_SHIFT+17:DIV_SHIFT];
      end
      if (cmd.cordic_init) begin
         x_ff    <= $signed({3'b000, root_ff, 8'h00});
         y_ff    <= $signed({{2{neg_ay[16]}}, neg_ay, 8'h00});
         z_ff    <= '0;
         zero_ff <= (root_ff == '0) && (ay_ff == '0);
      end else if (cmd.cordic_step) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
      if (cmd.angle) begin
         acc_ff <= acc_in;
         p1_ff  <= $signed({{3{pitch_ff[16]}}, pitch_ff}) - $signed({delta[18], delta});
      end
      if (cmd.prod) begin
         prod_g_ff <= $signed({1'b0, gyro_weight}) * p1_ff;
         prod_a_ff <= $signed({1'b0, acc_w}) * acc_ff;
      end
      if (cmd.final_step) begin
         acc_out_ff <= acc_ff;
         sat_ff     <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff    <= '0;
         div_busy_ff <= 1'b0;
      end else begin
         div_busy_ff <= cmd.square;
         if (cmd.final_step) begin
            pitch_ff <= pitch_in;
         end
      end
   end

   assign pitch_estimate = pitch_ff;
   assign accel_pitch    = acc_out_ff;
   assign saturated      = sat_ff;

endmodule

// ----- design/imu_complementary_pitch_unit.sv -----
// Each input transaction runs through 16 square-root steps and min(CORDIC_STEPS, 24)
// CORDIC iterations; its result is loaded once the output register is free.
// A new input transaction is accepted only once the previous one has finished;
// a finished result waits in the output register while the next item runs.
// Reset clears the kept pitch to zero and loads the register defaults.
// ----------------------------------------------------------------------------
// imu_complementary_pitch_unit
// Complementary-filter pitch estimator: accelerometer pitch by CORDIC
// vectoring blended with the integrated gyro rate; holds the register file.
// ----------------------------------------------------------------------------
module imu_complementary_pitch_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // accel_x, accel_y, accel_z, gyro_x
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // pitch_estimate[16:0], accel_pitch[32:17], zero fill
   output logic        rsp_tuser,   // saturated
   // register write port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import icp_pkg::*;

   logic [15:0]        sample_period_ff;
   logic signed [15:0] gyro_offset_ff;
   logic [15:0]        gyro_weight_ff;
   cmd_type            cmd;
   sts_type            sts;
   logic signed [16:0] pitch_estimate;
   logic signed [15:0] accel_pitch;
   logic               saturated;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff <= SAMPLE_PERIOD_RST;
         gyro_offset_ff   <= GYRO_OFFSET_RST;
         gyro_weight_ff   <= GYRO_WEIGHT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SAMPLE_PERIOD: sample_period_ff <= csr_data;
            CSR_GYRO_OFFSET:   gyro_offset_ff   <= csr_data;
            CSR_GYRO_WEIGHT:   gyro_weight_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   icp_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   icp_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_tdata      (req_tdata),
      .sample_period  (sample_period_ff),
      .gyro_offset    (gyro_offset_ff),
      .gyro_weight    (gyro_weight_ff),
      .pitch_estimate (pitch_estimate),
      .accel_pitch    (accel_pitch),
      .saturated      (saturated)
   );

   assign rsp_tdata = {7'd0, accel_pitch, pitch_estimate};
   assign rsp_tuser = saturated;

endmodule
